@@ src/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths and the part select type for the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package rmq_pkg;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Which part of the quaternion comes from the square root.
    typedef enum logic [1:0] {
        SEL_X = 2'd0,
        SEL_Y = 2'd1,
        SEL_Z = 2'd2,
        SEL_W = 2'd3
    } sel_t;
endpackage
`default_nettype wire

@@ src/rmq_stream_if.sv @@
// ----------------------------------------------------------------------------
// rmq_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface rmq_stream_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/rmq_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One restoring square root step: settles one result bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_sqrt_cell #(
    parameter int RW = 34,
    parameter int K  = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [RW-1:0] x_in,
    input  wire logic [RW-1:0] res_in,
    output logic [RW-1:0]      x_reg,
    output logic [RW-1:0]      res_reg
);
    logic [RW-1:0] bit_c;
    logic [RW-1:0] tr;
    logic [RW-1:0] x_next;
    logic [RW-1:0] res_next;

    assign bit_c = RW'(1) << (2 * K);
    assign tr    = res_in + bit_c;

    always_comb
    begin
        if (x_in >= tr)
        begin
            x_next   = x_in - tr;
            res_next = (res_in >> 1) + bit_c;
        end
        else
        begin
            x_next   = x_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            res_reg <= res_next;
        end
    end
endmodule
`default_nettype wire

@@ src/rmq_div_cell.sv @@
// ----------------------------------------------------------------------------
// rmq_div_cell
// One restoring division step for three numerators sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_div_cell #(
    parameter int NW = 40,
    parameter int K  = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] dv,
    input  wire logic [NW-1:0] rem_in [3],
    input  wire logic [NW-1:0] q_in   [3],
    output logic [NW-1:0]      rem_reg [3],
    output logic [NW-1:0]      q_reg   [3]
);
    logic [NW-1:0] rem_next [3];
    logic [NW-1:0] q_next   [3];
    logic [2*NW-1:0] sh;

    assign sh = {NW'(0), dv} << K;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            rem_next[j] = rem_in[j];
            q_next[j]   = q_in[j];
            if (sh[2*NW-1:NW] == '0 && rem_in[j] >= sh[NW-1:0])
            begin
                rem_next[j] = rem_in[j] - sh[NW-1:0];
                q_next[j]   = q_in[j] | (NW'(1) << K);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end
endmodule
`default_nettype wire

@@ src/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a fixed point rotation matrix to a quaternion.
// ----------------------------------------------------------------------------
// Usage: matrices enter on in_ch (nine signed elements packed m00 in the low
// bits through m22 in the high bits) and quaternions leave on out_ch packed
// w, x, y, z from the low bits with bad_input on top. One transfer per cycle
// is taken in both directions unless the receiver stalls. The path is a row
// of cells: one setup stage, one cell per square root bit (DATA_WIDTH+2 cells
// at default), one divider operand stage, one cell per quotient bit
// (DATA_WIDTH+2), and a rounding and saturation stage that feeds the output
// register. The whole row advances together; when the receiver stalls with
// the output register full, the row freezes and in_ch.ready drops. Reset
// clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    rmq_stream_if.sink   in_ch,
    rmq_stream_if.source out_ch
);
    localparam int DW  = DATA_WIDTH;
    localparam int SW  = DW + 3;              // sums of three elements
    localparam int RW  = 2 * ((SW + FRAC_BITS + 1) / 2) + 2;
    localparam int NSQ = RW / 2;
    localparam int SQW = NSQ + 1;
    localparam int NW  = DW + 2 + FRAC_BITS + 2;
    localparam int ND  = DW + 2;             // quotient bits after saturation
    localparam int LAT = NSQ + ND + 2;

    // ---------------- stage 0: setup ----------------
    logic signed [DW-1:0] m [9];
    logic signed [SW-1:0] tr, r_c;
    rmq_pkg::sel_t sel_c;
    logic signed [DW:0] d_c [3];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            m[k] = in_ch.data[k*DW +: DW];
        tr = SW'(m[0]) + SW'(m[4]) + SW'(m[8]);
        if (!tr[SW-1])
        begin
            sel_c = rmq_pkg::SEL_W;
            r_c = tr + SW'(1 << FRAC_BITS);
        end
        else
        begin
            if (m[8] > ((m[4] > m[0]) ? m[4] : m[0]))
                sel_c = rmq_pkg::SEL_Z;
            else if (m[4] > m[0])
                sel_c = rmq_pkg::SEL_Y;
            else
                sel_c = rmq_pkg::SEL_X;
            unique case (sel_c)
                rmq_pkg::SEL_X: r_c = SW'(m[0]) - SW'(m[4]) - SW'(m[8]);
                rmq_pkg::SEL_Y: r_c = SW'(m[4]) - SW'(m[8]) - SW'(m[0]);
                default:        r_c = SW'(m[8]) - SW'(m[0]) - SW'(m[4]);
            endcase
            r_c = r_c + SW'(1 << FRAC_BITS);
        end
        // three non-main parts, in order of w/x/y/z skipping the main one
        unique case (sel_c)
            rmq_pkg::SEL_W:
            begin
                d_c[0] = (DW+1)'(m[7]) - (DW+1)'(m[5]);
                d_c[1] = (DW+1)'(m[2]) - (DW+1)'(m[6]);
                d_c[2] = (DW+1)'(m[3]) - (DW+1)'(m[1]);
            end
            rmq_pkg::SEL_X:
            begin
                d_c[0] = (DW+1)'(m[7]) - (DW+1)'(m[5]);
                d_c[1] = (DW+1)'(m[3]) + (DW+1)'(m[1]);
                d_c[2] = (DW+1)'(m[2]) + (DW+1)'(m[6]);
            end
            rmq_pkg::SEL_Y:
            begin
                d_c[0] = (DW+1)'(m[2]) - (DW+1)'(m[6]);
                d_c[1] = (DW+1)'(m[3]) + (DW+1)'(m[1]);
                d_c[2] = (DW+1)'(m[7]) + (DW+1)'(m[5]);
            end
            default:
            begin
                d_c[0] = (DW+1)'(m[3]) - (DW+1)'(m[1]);
                d_c[1] = (DW+1)'(m[2]) + (DW+1)'(m[6]);
                d_c[2] = (DW+1)'(m[7]) + (DW+1)'(m[5]);
            end
        endcase
    end

    logic [LAT-1:0] v_reg;
    logic           adv;
    logic           ovalid_reg;
    assign adv = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[LAT-2:0], in_ch.valid};
    end

    // side data that travels alongside the cells
    typedef struct packed {
        logic [1:0] sel;
        logic       bad;
        logic [2:0] neg;
    } side_t;

    side_t                side_reg [LAT];
    logic [DW:0]          mag_reg  [NSQ+1][3];
    logic [RW-1:0]        x0_reg, res0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].sel <= sel_c;
            side_reg[0].bad <= r_c[SW-1] || (r_c == '0);
            for (int j = 0; j < 3; j++)
            begin
                side_reg[0].neg[j] <= d_c[j][DW];
                mag_reg[0][j] <= d_c[j][DW] ? (DW+1)'(-d_c[j]) : (DW+1)'(d_c[j]);
            end
            x0_reg   <= (r_c[SW-1] || r_c == '0) ? '0
                      : RW'({{(RW-SW){1'b0}}, r_c}) << FRAC_BITS;
            res0_reg <= '0;
            for (int s = 1; s < LAT; s++)
                side_reg[s] <= side_reg[s-1];
            for (int s = 1; s <= NSQ; s++)
                mag_reg[s] <= mag_reg[s-1];
        end
    end

    // ---------------- square root cells ----------------
    logic [RW-1:0] sx [NSQ+1];
    logic [RW-1:0] sr [NSQ+1];
    assign sx[0] = x0_reg;
    assign sr[0] = res0_reg;

    for (genvar g = 0; g < NSQ; g++)
    begin : g_sqrt
        rmq_sqrt_cell #(.RW(RW), .K(NSQ-1-g)) u_cell (
            .clk(clk), .en(adv),
            .x_in(sx[g]), .res_in(sr[g]),
            .x_reg(sx[g+1]), .res_reg(sr[g+1])
        );
    end

    // ---------------- divider operand stage ----------------
    logic [SQW-1:0] s_val;
    assign s_val = sr[NSQ][SQW-1:0];
    logic [SQW-1:0] main_reg [ND+1];
    logic [NW-1:0]  num0_reg [3];
    logic [NW-1:0]  dv_reg   [ND+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            main_reg[0] <= SQW'((SQW+1)'(s_val) + (SQW+1)'(1) >> 1);
            for (int j = 0; j < 3; j++)
                num0_reg[j] <= (NW'(mag_reg[NSQ][j]) << FRAC_BITS) + NW'(s_val);
            dv_reg[0] <= NW'({s_val, 1'b0});
            for (int s = 1; s < ND + 1; s++)
                dv_reg[s] <= dv_reg[s-1];
            for (int s = 1; s < ND + 1; s++)
                main_reg[s] <= main_reg[s-1];
        end
    end

    // ---------------- division cells ----------------
    logic [NW-1:0] rem_w [ND+1][3];
    logic [NW-1:0] q_w   [ND+1][3];
    assign rem_w[0] = num0_reg;
    assign q_w[0]   = '{default: '0};

    for (genvar g = 0; g < ND; g++)
    begin : g_div
        rmq_div_cell #(.NW(NW), .K(ND-1-g)) u_cell (
            .clk(clk), .en(adv),
            .dv(dv_reg[g]),
            .rem_in(rem_w[g]), .q_in(q_w[g]),
            .rem_reg(rem_w[g+1]), .q_reg(q_w[g+1])
        );
    end

    // A quotient bit beyond the cells means the value saturates anyway.
    logic hi_ov [3];
    always_comb
    begin
        for (int j = 0; j < 3; j++)
            hi_ov[j] = rem_w[ND][j] >= (dv_reg[ND] << ND) && dv_reg[ND] != '0
                       && ((dv_reg[ND] << ND) >> ND) == dv_reg[ND];
    end

    // ---------------- rounding, saturation, output register ----------------
    localparam logic signed [DW+2:0] HI = (DW+3)'((1 << (DW-1)) - 1);
    localparam logic signed [DW+2:0] LO = -HI - 1;
    side_t sd;
    assign sd = side_reg[LAT-1];
    logic [DW-1:0] part [3];
    logic [DW-1:0] mainv;
    logic [DW-1:0] q4 [4];
    logic signed [DW+2:0] t;

    always_comb
    begin
        t = '0;
        for (int j = 0; j < 3; j++)
        begin
            if (hi_ov[j] || q_w[ND][j][NW-1:DW+1] != '0)
                part[j] = sd.neg[j] ? LO[DW-1:0] : HI[DW-1:0];
            else
            begin
                t = (DW+3)'(q_w[ND][j][DW:0]);
                if (sd.neg[j]) t = -t;
                if (t > HI) t = HI;
                if (t < LO) t = LO;
                part[j] = t[DW-1:0];
            end
        end
        if (main_reg[ND] > SQW'(HI[DW-1:0]) && SQW >= DW)
            mainv = HI[DW-1:0];
        else
            mainv = DW'(main_reg[ND]);
        unique case (rmq_pkg::sel_t'(sd.sel))
            rmq_pkg::SEL_W: q4 = '{mainv, part[0], part[1], part[2]};
            rmq_pkg::SEL_X: q4 = '{part[0], mainv, part[1], part[2]};
            rmq_pkg::SEL_Y: q4 = '{part[0], part[1], mainv, part[2]};
            default:        q4 = '{part[0], part[1], part[2], mainv};
        endcase
        if (sd.bad)
            q4 = '{default: '0};
    end

    logic [4*DW:0] odata_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (adv)
            ovalid_reg <= v_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            odata_reg <= {sd.bad, q4[3], q4[2], q4[1], q4[0]};
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    // A stalled output must hold its data.
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ch.ready |=> ovalid_reg && $stable(odata_reg))
        else $error("output changed while stalled");
    // No transfer is accepted while the row is frozen.
    ap_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved while frozen");
    // A flagged result carries zero parts.
    ap_bad: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && odata_reg[4*DW] |-> odata_reg[4*DW-1:0] == '0)
        else $error("bad input with nonzero parts");
endmodule
`default_nettype wire
